// File: src/mdf_pkg.sv
// Shared types, codes and defaults of the duplicate frame filter.
`default_nettype none
package mdf_pkg;

  localparam int TABLE_DEPTH_DEF = 64;

  // Verdict codes
  localparam logic [1:0] VERDICT_NEW      = 2'd0;
  localparam logic [1:0] VERDICT_DUP      = 2'd1;
  localparam logic [1:0] VERDICT_FULL     = 2'd2;
  localparam logic [1:0] VERDICT_PASS     = 2'd3;

  // Register index (paddr[2])
  localparam logic REG_MAX_AGE = 1'b0;
  localparam logic REG_LIMIT   = 1'b1;

  localparam logic [31:0] MAX_AGE_RST = 32'd1000000;
  localparam logic [6:0]  LIMIT_RST   = 7'd64;

  typedef struct packed {
    logic        valid;
    logic [47:0] src;
    logic [47:0] dst;
    logic [39:0] tag;
    logic [31:0] stamp;
  } entry_t;

  typedef struct packed {
    logic live;    // valid and not expired
    logic expire;  // valid and older than max age
    logic match;   // live and key equal
  } eval_t;

endpackage
`default_nettype wire

// File: src/mdf_table.sv
// Entry store: one write port, one registered read port.
`default_nettype none
module mdf_table #(
  parameter int DEPTH = mdf_pkg::TABLE_DEPTH_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire logic           clk,
  input  wire logic           we,
  input  wire logic [AW-1:0]  waddr,
  input  wire mdf_pkg::entry_t wdata,
  input  wire logic [AW-1:0]  raddr,
  output mdf_pkg::entry_t     rdata
);

  mdf_pkg::entry_t mem [DEPTH];
  mdf_pkg::entry_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

// File: src/mdf_eval.sv
// Per-entry check: modular age against max age and key compare.
`default_nettype none
module mdf_eval (
  input  wire mdf_pkg::entry_t entry,
  input  wire logic [47:0]     key_src,
  input  wire logic [47:0]     key_dst,
  input  wire logic [39:0]     key_tag,
  input  wire logic [31:0]     now,
  input  wire logic [31:0]     max_age,
  output mdf_pkg::eval_t       res
);

  logic [31:0] age;
  logic        old;
  logic        same;

  assign age  = now - entry.stamp;
  assign old  = age > max_age;
  assign same = (entry.src == key_src) && (entry.dst == key_dst) && (entry.tag == key_tag);

  assign res.live   = entry.valid && !old;
  assign res.expire = entry.valid && old;
  assign res.match  = entry.valid && !old && same;

endmodule
`default_nettype wire

// File: src/message_duplicate_filter_unit.sv
// Top level of the duplicate frame filter: control, registers and result port.
`default_nettype none
// Duplicate frame filter with an aging table.
//
// Input: a frame header is taken at a rising edge with start high and busy low.
// Frames that are not of the 1905 type give verdict "pass" in the cycle after
// the transfer, with the current counter and occupancy, and busy stays low.
// A 1905 frame runs one pass over the table memory, one entry per cycle
// (read, age/compare, write back expired or refreshed entries), then one
// decide state that inserts the key into the lowest free entry if allowed.
// busy is high through the pass and the decide state; the result strobe
// out_valid is registered from the decide state, and the next frame is only
// taken once busy falls, since the pass uses the single table read port.
// Output: each result is on out_* for exactly one cycle with out_valid high;
// the receiver cannot stall and need not.
// Reset: after rst_n a clearing pass writes every entry invalid; busy is
// high during it. APB writes are taken at any time.
// Config: APB, reg 0 max_age_ticks at 0x0, reg 1 entry_limit at 0x4.
module message_duplicate_filter_unit #(
  parameter int TABLE_DEPTH = mdf_pkg::TABLE_DEPTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // input channel
  input  wire logic        start,
  output logic             busy,
  input  wire logic        in_is_ieee1905,
  input  wire logic [47:0] in_src_mac,
  input  wire logic [47:0] in_dst_mac,
  input  wire logic [15:0] in_message_type,
  input  wire logic [15:0] in_message_id,
  input  wire logic [7:0]  in_fragment_index,
  input  wire logic [31:0] in_now_ticks,
  // result channel
  output logic             out_valid,
  output logic [1:0]       out_verdict,
  output logic [31:0]      out_duplicate_total,
  output logic [6:0]       out_occupancy,
  // configuration
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int LW = (CW > 7) ? CW : 7;

  // controller states
  localparam logic [1:0] ST_CLEAR  = 2'd0;
  localparam logic [1:0] ST_IDLE   = 2'd1;
  localparam logic [1:0] ST_SCAN   = 2'd2;
  localparam logic [1:0] ST_DECIDE = 2'd3;

  logic [1:0]    state_r, state_nxt;
  logic [AW-1:0] idx_r, idx_nxt;          // entry under check / being cleared
  logic          hit_r, hit_nxt;
  logic          free_found_r, free_found_nxt;
  logic [AW-1:0] free_idx_r, free_idx_nxt;
  logic [CW-1:0] valid_count_r, valid_count_nxt;
  logic [31:0]   dup_count_r, dup_count_nxt;

  // frame key held for the pass
  logic [47:0]   key_src_r;
  logic [47:0]   key_dst_r;
  logic [39:0]   key_tag_r;
  logic [31:0]   key_now_r;

  logic [31:0]   max_age_r;
  logic [6:0]    limit_r;

  logic          out_valid_r, out_valid_nxt;
  logic [1:0]    out_verdict_r, out_verdict_nxt;
  logic [31:0]   out_dup_r, out_dup_nxt;
  logic [6:0]    out_occ_r, out_occ_nxt;

  logic          accept;
  logic          last_idx;

  // memory ports
  logic            mem_we;
  logic [AW-1:0]   mem_waddr;
  mdf_pkg::entry_t mem_wdata;
  logic [AW-1:0]   mem_raddr;
  mdf_pkg::entry_t mem_rdata;
  mdf_pkg::eval_t  ev;

  // decide cycle
  logic [LW-1:0] limit_ext, depth_ext, limit_sat, count_ext, occ_ext;
  logic          table_full;
  logic          do_insert;

  assign accept   = start && !busy;
  assign busy     = (state_r != ST_IDLE);
  assign last_idx = (idx_r == AW'(TABLE_DEPTH - 1));

  // ---------------------------------------------------------------------------
  // APB registers; pready tied high, index taken from paddr[2]
  // ---------------------------------------------------------------------------
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_age_r <= mdf_pkg::MAX_AGE_RST;
      limit_r   <= mdf_pkg::LIMIT_RST;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[2])
        mdf_pkg::REG_MAX_AGE: max_age_r <= pwdata;
        mdf_pkg::REG_LIMIT:   limit_r   <= pwdata[6:0];
        default:              max_age_r <= max_age_r;
      endcase
    end
  end

  assign prdata = (paddr[2] == mdf_pkg::REG_LIMIT) ? {25'd0, limit_r} : max_age_r;

  // ---------------------------------------------------------------------------
  // Table memory and per-entry check
  // ---------------------------------------------------------------------------
  mdf_table #(
    .DEPTH (TABLE_DEPTH),
    .AW    (AW)
  ) u_table (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  mdf_eval u_eval (
    .entry   (mem_rdata),
    .key_src (key_src_r),
    .key_dst (key_dst_r),
    .key_tag (key_tag_r),
    .now     (key_now_r),
    .max_age (max_age_r),
    .res     (ev)
  );

  // Read one entry ahead: entry 0 is read at the transfer edge, entry i+1
  // while entry i is written back, so a read never hits the entry being written.
  assign mem_raddr = (state_r == ST_SCAN) ? (idx_r + 1'b1) : '0;

  // limit saturates at the table depth
  assign limit_ext  = LW'(limit_r);
  assign depth_ext  = LW'(TABLE_DEPTH);
  assign limit_sat  = (limit_ext > depth_ext) ? depth_ext : limit_ext;
  assign count_ext  = LW'(valid_count_r);
  assign table_full = (count_ext >= limit_sat);
  assign do_insert  = !hit_r && !table_full && free_found_r;

  always_comb begin
    state_nxt       = state_r;
    idx_nxt         = idx_r;
    hit_nxt         = hit_r;
    free_found_nxt  = free_found_r;
    free_idx_nxt    = free_idx_r;
    valid_count_nxt = valid_count_r;
    dup_count_nxt   = dup_count_r;
    out_valid_nxt   = 1'b0;
    out_verdict_nxt = out_verdict_r;
    out_dup_nxt     = out_dup_r;
    out_occ_nxt     = out_occ_r;
    mem_we          = 1'b0;
    mem_waddr       = idx_r;
    mem_wdata       = mem_rdata;
    occ_ext         = LW'(valid_count_r);

    unique case (state_r)
      ST_CLEAR: begin
        mem_we          = 1'b1;
        mem_wdata       = '0;
        idx_nxt         = idx_r + 1'b1;
        if (last_idx) begin
          state_nxt = ST_IDLE;
        end
      end

      ST_IDLE: begin
        if (accept) begin
          if (in_is_ieee1905) begin
            state_nxt      = ST_SCAN;
            idx_nxt        = '0;
            hit_nxt        = 1'b0;
            free_found_nxt = 1'b0;
          end else begin
            out_valid_nxt   = 1'b1;
            out_verdict_nxt = mdf_pkg::VERDICT_PASS;
            out_dup_nxt     = dup_count_r;
            out_occ_nxt     = occ_ext[6:0];
          end
        end
      end

      ST_SCAN: begin
        // expired entries drop out, the first live match gets a fresh stamp
        if (ev.expire) begin
          mem_we          = 1'b1;
          mem_wdata.valid = 1'b0;
          if (valid_count_r != '0) begin
            valid_count_nxt = valid_count_r - 1'b1;
          end
        end else if (ev.match && !hit_r) begin
          mem_we          = 1'b1;
          mem_wdata.stamp = key_now_r;
          hit_nxt         = 1'b1;
        end
        if (!ev.live && !free_found_r) begin
          free_found_nxt = 1'b1;
          free_idx_nxt   = idx_r;
        end
        idx_nxt = idx_r + 1'b1;
        if (last_idx) begin
          state_nxt = ST_DECIDE;
        end
      end

      ST_DECIDE: begin
        state_nxt     = ST_IDLE;
        out_valid_nxt = 1'b1;
        mem_waddr     = free_idx_r;
        mem_wdata     = {1'b1, key_src_r, key_dst_r, key_tag_r, key_now_r};
        priority if (hit_r) begin
          dup_count_nxt   = dup_count_r + 32'd1;
          out_verdict_nxt = mdf_pkg::VERDICT_DUP;
        end else if (do_insert) begin
          mem_we          = 1'b1;
          valid_count_nxt = valid_count_r + 1'b1;
          out_verdict_nxt = mdf_pkg::VERDICT_NEW;
        end else begin
          out_verdict_nxt = mdf_pkg::VERDICT_FULL;
        end
        occ_ext     = LW'(valid_count_nxt);
        out_dup_nxt = dup_count_nxt;
        out_occ_nxt = occ_ext[6:0];
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_CLEAR;
      idx_r         <= '0;
      hit_r         <= 1'b0;
      free_found_r  <= 1'b0;
      valid_count_r <= '0;
      dup_count_r   <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      idx_r         <= idx_nxt;
      hit_r         <= hit_nxt;
      free_found_r  <= free_found_nxt;
      valid_count_r <= valid_count_nxt;
      dup_count_r   <= dup_count_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    free_idx_r    <= free_idx_nxt;
    out_verdict_r <= out_verdict_nxt;
    out_dup_r     <= out_dup_nxt;
    out_occ_r     <= out_occ_nxt;
    if (accept) begin
      key_src_r <= in_src_mac;
      key_dst_r <= in_dst_mac;
      key_tag_r <= {in_message_type, in_message_id, in_fragment_index};
      key_now_r <= in_now_ticks;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_verdict         = out_verdict_r;
  assign out_duplicate_total = out_dup_r;
  assign out_occupancy       = out_occ_r;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_strobe_source: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $past(state_r == ST_DECIDE ||
                          (state_r == ST_IDLE && start && !in_is_ieee1905)))
    else $error("result strobe without a finished frame");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    valid_count_r <= CW'(TABLE_DEPTH))
    else $error("occupancy above table depth");

  a_1905_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_is_ieee1905) |=> (busy && !out_valid_r))
    else $error("1905 frame did not start a table pass");

  a_no_idle_write: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (state_r != ST_IDLE))
    else $error("table write while idle");

endmodule
`default_nettype wire
